FILE: hw/rtl/serial_line_value_parser_assert.svh
// Assertion macros shared by the line parser RTL.
`ifndef SERIAL_LINE_VALUE_PARSER_ASSERT_SVH
`define SERIAL_LINE_VALUE_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define SLVP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define SLVP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SLVP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SLVP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/slvp_pkg.sv
// Package with the types, codes and helpers of the serial line value parser.
package slvp_pkg;

    localparam int LINE_CAPACITY_DEF = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_NUMBER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARSE_MODE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_TIER  = 3'd4;

    localparam logic [7:0] CH_BS        = 8'h08;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_PRINT_MAX = 8'h7E;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_E         = 8'h45;
    localparam logic [7:0] CH_M         = 8'h4D;
    localparam logic [7:0] CH_H         = 8'h48;
    localparam logic [7:0] CH_C         = 8'h43;

    localparam logic KIND_ECHO  = 1'b0;
    localparam logic KIND_PARSE = 1'b1;

    localparam logic MODE_NUMBER = 1'b0;

    localparam logic [1:0] ST_PARSED  = 2'd0;
    localparam logic [1:0] ST_BOUNDS  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_LENGTH  = 2'd3;

    localparam logic [1:0] TIER_E = 2'd0;
    localparam logic [1:0] TIER_M = 2'd1;
    localparam logic [1:0] TIER_H = 2'd2;
    localparam logic [1:0] TIER_C = 2'd3;

    typedef enum logic [1:0] {
        SEQ_CHAR,
        SEQ_ERASE,
        SEQ_EOL
    } t_seq_kind;

    typedef struct packed {
        logic        kind;
        logic [7:0]  echo_byte;
        logic [31:0] number;
        logic [1:0]  tier;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // Control of the decimal accumulator.
    typedef struct packed {
        logic clear;
        logic step;
    } t_acc_ctl;

    // Index of the final echo of a sequence.
    function automatic logic [1:0] seq_final(input t_seq_kind kind);
        logic [1:0] idx;
        case (kind)
            SEQ_ERASE: idx = 2'd2;
            SEQ_EOL:   idx = 2'd1;
            default:   idx = 2'd0;
        endcase
        return idx;
    endfunction

    // Echo byte at a given position of a sequence.
    function automatic logic [7:0] seq_byte(input t_seq_kind kind, input logic [1:0] idx,
                                            input logic [7:0] ch);
        logic [7:0] b;
        case (kind)
            SEQ_ERASE: b = (idx == 2'd1) ? CH_SPACE : CH_BS;
            SEQ_EOL:   b = (idx == 2'd0) ? CH_CR : CH_LF;
            default:   b = ch;
        endcase
        return b;
    endfunction

endpackage

FILE: hw/rtl/slvp_in_if.sv
// Valid/ready channel that carries received bytes.
interface slvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/slvp_out_if.sv
// Valid/ready channel that carries echo bytes and parse results.
interface slvp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  echo_byte;
    logic [31:0] number;
    logic [1:0]  tier;
    logic [1:0]  status;
    logic        last;

    modport source (output valid, output kind, output echo_byte, output number,
                    output tier, output status, output last, input ready);
    modport sink (input valid, input kind, input echo_byte, input number,
                  input tier, input status, input last, output ready);
endinterface

FILE: hw/rtl/serial_line_value_parser.sv
// Top level of the serial line value parser: line editing, echo and end-of-line parse.
//
// Received bytes are taken one transaction at a time and edited into a line held in a
// single-port synchronous store. A printable byte is accepted and then echoed; an erase
// on a non-empty line is accepted and echoed as backspace, space, backspace. A line end
// is accepted, echoed as CR and LF, walked and answered with the result. The walk reads
// the store through its one read port, one character per cycle into a multiply-by-ten
// accumulator, and folds in the last read before the result when the line is not empty.
// A printable byte on a full line is not stored, skips its echo and ends the line. Output
// stalls hold echoes and results; the next byte is taken while the last result still waits
// to be read. No clearing pass follows reset: only entries below the line length are read.
`include "serial_line_value_parser_assert.svh"

module serial_line_value_parser #(
    parameter int LINE_CAPACITY = slvp_pkg::LINE_CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    slvp_in_if.sink                         i_rx,
    slvp_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [slvp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slvp_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import slvp_pkg::*;

    localparam int AW = $clog2(LINE_CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ECHO   = 4'b0010,
        S_READ   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state      r_state, n_state;
    logic [AW-1:0] r_len, n_len;
    t_seq_kind   r_seq_kind, n_seq_kind;
    logic [1:0]  r_seq_idx, n_seq_idx;
    logic [7:0]  r_char, n_char;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic        r_rd_pend, n_rd_pend;
    logic        r_rd_first, n_rd_first;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_rd_data;
    logic [7:0]  r_mem [LINE_CAPACITY];

    logic [31:0] r_low_limit;
    logic [31:0] r_high_limit;
    logic [31:0] r_default_number;
    logic        r_parse_mode;
    logic [1:0]  r_fallback_tier;

    t_result     r_out;
    logic        r_out_valid;
    t_result     load_val;
    t_result     parse_res;
    logic        load;
    logic        can_load;
    logic        in_accept;
    logic        is_eol;
    logic        is_erase;
    logic        is_print;
    logic        mem_we;
    logic        rd_issue;
    t_acc_ctl    acc_ctl;
    logic [31:0] acc_value;
    logic        acc_oob;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit      <= '0;
            r_high_limit     <= '1;
            r_default_number <= '0;
            r_parse_mode     <= MODE_NUMBER;
            r_fallback_tier  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOW_LIMIT:      r_low_limit      <= i_cfg_wdata;
                CFG_HIGH_LIMIT:     r_high_limit     <= i_cfg_wdata;
                CFG_DEFAULT_NUMBER: r_default_number <= i_cfg_wdata;
                CFG_PARSE_MODE:     r_parse_mode     <= i_cfg_wdata[0];
                CFG_FALLBACK_TIER:  r_fallback_tier  <= i_cfg_wdata[1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_rx.ready = (r_state == S_IDLE);
    assign in_accept  = i_rx.valid && (r_state == S_IDLE);
    assign can_load   = !r_out_valid || o_res.ready;

    assign is_eol   = i_rx.rx_byte inside {CH_CR, CH_LF};
    assign is_erase = i_rx.rx_byte inside {CH_BS, CH_DEL};
    assign is_print = i_rx.rx_byte inside {[CH_SPACE:CH_PRINT_MAX]};

    slvp_decimal u_decimal (
        .i_clk           (i_clk),
        .i_ctl           (acc_ctl),
        .i_char          (r_rd_data),
        .i_lower         (r_low_limit),
        .i_upper         (r_high_limit),
        .o_value         (acc_value),
        .o_out_of_bounds (acc_oob)
    );

    // Result of the finished line.
    always_comb begin
        parse_res           = '0;
        parse_res.kind      = KIND_PARSE;
        parse_res.last      = 1'b1;
        if (r_parse_mode == MODE_NUMBER) begin
            if (r_len == '0) begin
                parse_res.number = r_default_number;
                parse_res.status = ST_INVALID;
            end else if (acc_oob) begin
                parse_res.number = r_default_number;
                parse_res.status = ST_BOUNDS;
            end else begin
                parse_res.number = acc_value;
                parse_res.status = ST_PARSED;
            end
        end else if (r_len == AW'(1)) begin
            case (r_first)
                CH_E: parse_res.tier = TIER_E;
                CH_M: parse_res.tier = TIER_M;
                CH_H: parse_res.tier = TIER_H;
                CH_C: parse_res.tier = TIER_C;
                default: begin
                    parse_res.tier   = r_fallback_tier;
                    parse_res.status = ST_INVALID;
                end
            endcase
        end else begin
            parse_res.tier   = r_fallback_tier;
            parse_res.status = ST_LENGTH;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_len      = r_len;
        n_seq_kind = r_seq_kind;
        n_seq_idx  = r_seq_idx;
        n_char     = r_char;
        n_rd_idx   = r_rd_idx;
        n_rd_pend  = r_rd_pend;
        n_rd_first = r_rd_first;
        n_first    = r_first;
        mem_we     = 1'b0;
        rd_issue   = 1'b0;
        acc_ctl    = '0;
        load       = 1'b0;
        load_val   = r_out;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (is_eol) begin
                        n_seq_kind = SEQ_EOL;
                        n_seq_idx  = '0;
                        n_state    = S_ECHO;
                    end else if (is_erase) begin
                        if (r_len != '0) begin
                            n_len      = r_len - AW'(1);
                            n_seq_kind = SEQ_ERASE;
                            n_seq_idx  = '0;
                            n_state    = S_ECHO;
                        end
                    end else if (is_print) begin
                        if (r_len != AW'(LINE_CAPACITY - 1)) begin
                            mem_we     = 1'b1;
                            n_len      = r_len + AW'(1);
                            n_char     = i_rx.rx_byte;
                            n_seq_kind = SEQ_CHAR;
                            n_seq_idx  = '0;
                            n_state    = S_ECHO;
                        end else begin
                            // A printable byte on a full line ends it without echo.
                            n_rd_idx      = '0;
                            n_rd_pend     = 1'b0;
                            acc_ctl.clear = 1'b1;
                            n_state       = S_READ;
                        end
                    end
                end
            end
            S_ECHO: begin
                if (can_load) begin
                    load               = 1'b1;
                    load_val           = '0;
                    load_val.kind      = KIND_ECHO;
                    load_val.echo_byte = seq_byte(r_seq_kind, r_seq_idx, r_char);
                    load_val.last      = (r_seq_kind != SEQ_EOL)
                                         && (r_seq_idx == seq_final(r_seq_kind));
                    if (r_seq_idx == seq_final(r_seq_kind)) begin
                        if (r_seq_kind == SEQ_EOL) begin
                            n_rd_idx      = '0;
                            n_rd_pend     = 1'b0;
                            acc_ctl.clear = 1'b1;
                            n_state       = S_READ;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_seq_idx = r_seq_idx + 2'd1;
                    end
                end
            end
            S_READ: begin
                // One read is issued per cycle; its data is folded in the next cycle.
                acc_ctl.step = r_rd_pend;
                if (r_rd_pend && r_rd_first) begin
                    n_first = r_rd_data;
                end
                if (r_rd_idx != r_len) begin
                    rd_issue   = 1'b1;
                    n_rd_idx   = r_rd_idx + AW'(1);
                    n_rd_pend  = 1'b1;
                    n_rd_first = (r_rd_idx == '0);
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (can_load) begin
                    load     = 1'b1;
                    load_val = parse_res;
                    n_len    = '0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_len     <= n_len;
            r_rd_pend <= n_rd_pend;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq_kind <= n_seq_kind;
        r_seq_idx  <= n_seq_idx;
        r_char     <= n_char;
        r_rd_idx   <= n_rd_idx;
        r_rd_first <= n_rd_first;
        r_first    <= n_first;
        if (load) begin
            r_out <= load_val;
        end
    end

    // Line store: written while idle, read while the line is walked.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_len] <= i_rx.rx_byte;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_out.kind;
    assign o_res.echo_byte = r_out.echo_byte;
    assign o_res.number    = r_out.number;
    assign o_res.tier      = r_out.tier;
    assign o_res.status    = r_out.status;
    assign o_res.last      = r_out.last;

    `SLVP_ASSERT_IMPL(a_read_in_line, i_clk, i_rst_n, rd_issue, r_rd_idx < r_len)
    `SLVP_ASSERT_IMPL(a_no_write_in_walk, i_clk, i_rst_n, r_state != S_IDLE, !mem_we)
    `SLVP_ASSERT_NEXT(a_line_cleared, i_clk, i_rst_n, load && (r_state == S_FINISH), r_len == '0)
    `SLVP_ASSERT_NEXT(a_erase_shrinks, i_clk, i_rst_n, in_accept && is_erase && (r_len != '0), r_len == $past(r_len) - AW'(1))

endmodule

FILE: hw/rtl/slvp_decimal.sv
// Decimal accumulator with bounds check, fed one stored character per step.
module slvp_decimal (
    input  logic              i_clk,
    input  slvp_pkg::t_acc_ctl i_ctl,
    input  logic [7:0]        i_char,
    input  logic [31:0]       i_lower,
    input  logic [31:0]       i_upper,
    output logic [31:0]       o_value,
    output logic              o_out_of_bounds
);
    import slvp_pkg::*;

    logic [31:0] r_value;
    logic [31:0] n_value;

    // Times ten as two shifts; the weight wraps modulo 2^32 for non-digits.
    always_comb begin
        n_value = r_value;
        if (i_ctl.clear) begin
            n_value = '0;
        end else if (i_ctl.step) begin
            n_value = {r_value[28:0], 3'b000} + {r_value[30:0], 1'b0}
                      + {24'd0, i_char} - {24'd0, CH_ZERO};
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_out_of_bounds = (r_value < i_lower) || (r_value > i_upper);

endmodule
